// ===== design/tswg_pkg.sv =====
// shared types and constants of the triangle / trapezoid waveform generator
// no dependencies; every other file refers to it by scoped names
package tswg_pkg;

    localparam int SAMP_W = 13;
    localparam int LEN_W  = 11;
    localparam int POS_W  = LEN_W + 1;
    localparam int RISE_W = 10;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 13;
    localparam int PROD_W = SAMP_W + LEN_W;

    // quotient of every ramp is at most the span, so it fits in a sample
    localparam int DIV_STEPS = SAMP_W;

    typedef logic [SAMP_W-1:0] samp_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [RISE_W-1:0] rise_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [PROD_W-1:0] prod_t;

    localparam samp_t FULL_SCALE = samp_t'(4096);

    // register indexes of the write port
    localparam addr_t REG_WAVE_MODE   = addr_t'(0);
    localparam addr_t REG_LOW_LEVEL   = addr_t'(1);
    localparam addr_t REG_HIGH_LEVEL  = addr_t'(2);
    localparam addr_t REG_PERIOD_LEN  = addr_t'(3);
    localparam addr_t REG_BREAK_POINT = addr_t'(4);
    localparam addr_t REG_RISE_LEN    = addr_t'(5);

    localparam samp_t RST_HIGH_LEVEL  = samp_t'(4096);
    localparam len_t  RST_PERIOD_LEN  = len_t'(1024);
    localparam len_t  RST_BREAK_POINT = len_t'(512);

    // both queues are two entries deep
    typedef logic [0:0] qptr_t;
    typedef logic [1:0] qcnt_t;
    localparam qcnt_t Q_FULL = qcnt_t'(2);

    // settings after saturation, with the ramp boundaries worked out
    typedef struct packed {
        logic  mode;
        samp_t lo;
        samp_t hi;
        samp_t span;
        samp_t mid;
        len_t  per;
        len_t  bp;
        len_t  fall;
        len_t  rise;
        len_t  half;
        len_t  off_lo;
        pos_t  off_hi;
        len_t  top_end;
    } cfg_t;

    // one sample job: base plus or minus span * num / den
    typedef struct packed {
        samp_t base;
        samp_t span;
        len_t  num;
        len_t  den;
        logic  sub;
        logic  pend;
    } job_t;

endpackage

// ===== design/triangle_square_waveform_generator_unit.sv =====
// top level of the triangle / trapezoid waveform generator
// depends on tswg_pkg, tswg_cfg, tswg_front and tswg_back
//
// Use: each transfer on the input side (push while full is low) asks for the
// next sample of the waveform; restart set on that transfer puts the phase back
// to zero first. Each request gives exactly one result: sample, the DAC code,
// and period_end, set on the last sample of a period. Results wait in a
// two-entry queue; the oldest is on the ports while empty is low and leaves on
// a transfer with pop high.
// Settings are written through cfg_we / cfg_addr / cfg_wdata while nothing is
// in flight; writes to unknown indexes are ignored.
// Timing: requests are taken one a cycle into the front end until its job queue
// fills. A ramp sample passes the back end in order: taking the job, the span
// times offset multiply, the bit-serial divide and queueing the sample; a flat
// sample skips the divide. The back end takes a new job only after it has queued
// the sample of the last one.
// Reset clears the phase, both queues and the settings to their defaults.
// A stalled receiver fills the result queue, then the back end, then the job
// queue, and finally raises full; nothing is dropped.
module triangle_square_waveform_generator_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            restart,
    output logic            empty,
    input  logic            pop,
    output tswg_pkg::samp_t sample,
    output logic            period_end,
    input  logic            cfg_we,
    input  tswg_pkg::addr_t cfg_addr,
    input  tswg_pkg::data_t cfg_wdata
);

    tswg_pkg::len_t per_now;
    tswg_pkg::cfg_t cfg;
    tswg_pkg::job_t job;
    logic           job_valid;
    logic           job_pop;

    tswg_cfg #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .per_now   (per_now),
        .cfg       (cfg)
    );

    tswg_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .restart   (restart),
        .full      (full),
        .per_now   (per_now),
        .cfg       (cfg),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    tswg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .job_valid  (job_valid),
        .job_pop    (job_pop),
        .pop        (pop),
        .empty      (empty),
        .sample     (sample),
        .period_end (period_end)
    );

endmodule

// ===== design/tswg_cfg.sv =====
// configuration registers and the registered, saturated settings derived from them
// depends on tswg_pkg
module tswg_cfg #(
    parameter int MAX_POINTS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  tswg_pkg::addr_t  cfg_addr,
    input  tswg_pkg::data_t  cfg_wdata,
    output tswg_pkg::len_t   per_now,
    output tswg_pkg::cfg_t   cfg
);

    localparam int LEN_MAX = (1 << tswg_pkg::LEN_W) - 1;
    localparam tswg_pkg::len_t MAX_LEN =
        tswg_pkg::len_t'((MAX_POINTS < LEN_MAX) ? MAX_POINTS : LEN_MAX);

    logic            wave_mode_reg;
    tswg_pkg::samp_t low_level_reg;
    tswg_pkg::samp_t high_level_reg;
    tswg_pkg::len_t  period_len_reg;
    tswg_pkg::len_t  break_point_reg;
    tswg_pkg::rise_t rise_len_reg;

    tswg_pkg::cfg_t  cfg_reg;
    tswg_pkg::cfg_t  cfg_next;

    tswg_pkg::len_t  per_c;
    tswg_pkg::samp_t lo_c;
    tswg_pkg::samp_t hi_sat;
    tswg_pkg::samp_t hi_c;
    tswg_pkg::len_t  bp_c;
    tswg_pkg::len_t  per_half;
    tswg_pkg::len_t  rise_raw;
    tswg_pkg::len_t  rise_c;
    tswg_pkg::len_t  half_c;
    tswg_pkg::len_t  off_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg   <= 1'b0;
            low_level_reg   <= '0;
            high_level_reg  <= tswg_pkg::RST_HIGH_LEVEL;
            period_len_reg  <= tswg_pkg::RST_PERIOD_LEN;
            break_point_reg <= tswg_pkg::RST_BREAK_POINT;
            rise_len_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tswg_pkg::REG_WAVE_MODE:   wave_mode_reg   <= cfg_wdata[0];
                tswg_pkg::REG_LOW_LEVEL:   low_level_reg   <= cfg_wdata[tswg_pkg::SAMP_W-1:0];
                tswg_pkg::REG_HIGH_LEVEL:  high_level_reg  <= cfg_wdata[tswg_pkg::SAMP_W-1:0];
                tswg_pkg::REG_PERIOD_LEN:  period_len_reg  <= cfg_wdata[tswg_pkg::LEN_W-1:0];
                tswg_pkg::REG_BREAK_POINT: break_point_reg <= cfg_wdata[tswg_pkg::LEN_W-1:0];
                tswg_pkg::REG_RISE_LEN:    rise_len_reg    <= cfg_wdata[tswg_pkg::RISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        per_c = (period_len_reg > MAX_LEN) ? MAX_LEN : period_len_reg;
        if (per_c == '0)
        begin
            per_c = tswg_pkg::len_t'(1);
        end
        lo_c     = (low_level_reg > tswg_pkg::FULL_SCALE) ? tswg_pkg::FULL_SCALE : low_level_reg;
        hi_sat   = (high_level_reg > tswg_pkg::FULL_SCALE) ? tswg_pkg::FULL_SCALE
                                                           : high_level_reg;
        hi_c     = (hi_sat < lo_c) ? lo_c : hi_sat;
        bp_c     = (break_point_reg > per_c) ? per_c : break_point_reg;
        per_half = per_c >> 1;
        rise_raw = tswg_pkg::len_t'(rise_len_reg);
        rise_c   = (rise_raw > per_half) ? per_half : rise_raw;
        half_c   = rise_c >> 1;
        // square off time never shorter than half a ramp
        off_c    = (bp_c < half_c) ? half_c : bp_c;

        cfg_next.mode    = wave_mode_reg;
        cfg_next.lo      = lo_c;
        cfg_next.hi      = hi_c;
        cfg_next.span    = hi_c - lo_c;
        cfg_next.mid     = lo_c + ((hi_c - lo_c) >> 1);
        cfg_next.per     = per_c;
        cfg_next.bp      = bp_c;
        cfg_next.fall    = per_c - bp_c;
        cfg_next.rise    = rise_c;
        cfg_next.half    = half_c;
        cfg_next.off_lo  = off_c - half_c;
        cfg_next.off_hi  = tswg_pkg::pos_t'(off_c) + tswg_pkg::pos_t'(half_c);
        cfg_next.top_end = per_c - half_c;
    end

    // user keeps settings stable in flight, unchecked; one register level suffices
    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign per_now = per_c;
    assign cfg     = cfg_reg;

endmodule

// ===== design/tswg_front.sv =====
// front end: takes requests, steps the phase, sorts each sample into its
// waveform segment and queues the resulting job; depends on tswg_pkg
module tswg_front #(
    parameter int MAX_POINTS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            restart,
    output logic            full,
    input  tswg_pkg::len_t  per_now,
    input  tswg_pkg::cfg_t  cfg,
    output tswg_pkg::job_t  job,
    output logic            job_valid,
    input  logic            job_pop
);

    localparam int PHASE_W = ($clog2(MAX_POINTS) < tswg_pkg::LEN_W) ? $clog2(MAX_POINTS)
                                                                     : tswg_pkg::LEN_W;
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] cur_i;
    logic               cur_pend;
    logic               accept;

    logic               hold_valid_reg;
    logic               hold_valid_next;
    logic [PHASE_W-1:0] hold_i_reg;
    logic               hold_pend_reg;

    tswg_pkg::len_t     il;
    tswg_pkg::pos_t     ix;
    tswg_pkg::job_t     job_c;

    tswg_pkg::job_t     jq_mem_reg [2];
    tswg_pkg::qptr_t    jq_wr_ptr_reg;
    tswg_pkg::qptr_t    jq_rd_ptr_reg;
    tswg_pkg::qcnt_t    jq_cnt_reg;
    tswg_pkg::qcnt_t    jq_cnt_next;
    logic               jq_push;

    // phase stepping
    always_comb
    begin
        if (restart || (tswg_pkg::len_t'(phase_reg) >= per_now))
        begin
            cur_i = '0;
        end
        else
        begin
            cur_i = phase_reg;
        end
        cur_pend   = (tswg_pkg::len_t'(cur_i) == tswg_pkg::len_t'(per_now - tswg_pkg::len_t'(1)));
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = cur_pend ? '0 : cur_i + PHASE_ONE;
        end
    end

    assign jq_push = hold_valid_reg && (jq_cnt_reg != tswg_pkg::Q_FULL);
    assign full    = hold_valid_reg && (jq_cnt_reg == tswg_pkg::Q_FULL);
    assign accept  = push && !full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (jq_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // segment classification
    always_comb
    begin
        il = tswg_pkg::len_t'(hold_i_reg);
        ix = tswg_pkg::pos_t'(hold_i_reg);
        job_c.base = cfg.lo;
        job_c.span = cfg.span;
        job_c.num  = '0;
        job_c.den  = '0;
        job_c.sub  = 1'b0;
        job_c.pend = hold_pend_reg;
        if (!cfg.mode)
        begin
            if (il < cfg.bp)
            begin
                job_c.num = il;
                job_c.den = cfg.bp;
            end
            else
            begin
                job_c.base = cfg.hi;
                job_c.sub  = 1'b1;
                job_c.num  = il - cfg.bp;
                job_c.den  = cfg.fall;
            end
        end
        else
        begin
            priority if (il < cfg.half)
            begin
                // closing half of the falling edge, from mid level
                job_c.base = cfg.mid;
                job_c.sub  = 1'b1;
                job_c.num  = il;
                job_c.den  = cfg.rise;
            end
            else if (il < cfg.off_lo)
            begin
                job_c.base = cfg.lo;
            end
            else if (ix < cfg.off_hi)
            begin
                job_c.num = il - cfg.off_lo;
                job_c.den = cfg.rise;
            end
            else if (il < cfg.top_end)
            begin
                job_c.base = cfg.hi;
            end
            else
            begin
                job_c.base = cfg.hi;
                job_c.sub  = 1'b1;
                job_c.num  = il - cfg.top_end;
                job_c.den  = cfg.rise;
            end
        end
    end

    always_comb
    begin
        jq_cnt_next = jq_cnt_reg;
        unique case ({jq_push, job_pop})
            2'b10:   jq_cnt_next = jq_cnt_reg + tswg_pkg::qcnt_t'(1);
            2'b01:   jq_cnt_next = jq_cnt_reg - tswg_pkg::qcnt_t'(1);
            default: jq_cnt_next = jq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            hold_valid_reg <= 1'b0;
            jq_wr_ptr_reg  <= '0;
            jq_rd_ptr_reg  <= '0;
            jq_cnt_reg     <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hold_valid_reg <= hold_valid_next;
            jq_cnt_reg     <= jq_cnt_next;
            if (jq_push)
            begin
                jq_wr_ptr_reg <= jq_wr_ptr_reg + tswg_pkg::qptr_t'(1);
            end
            if (job_pop)
            begin
                jq_rd_ptr_reg <= jq_rd_ptr_reg + tswg_pkg::qptr_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_i_reg    <= cur_i;
            hold_pend_reg <= cur_pend;
        end
        if (jq_push)
        begin
            jq_mem_reg[jq_wr_ptr_reg] <= job_c;
        end
    end

    assign job       = jq_mem_reg[jq_rd_ptr_reg];
    assign job_valid = (jq_cnt_reg != '0);

`ifndef SYNTH
    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cur_pend) |=> (phase_reg == '0))
        else $error("phase did not wrap after the last sample of a period");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> ((job.den == '0) || (job.num < job.den)))
        else $error("queued ramp offset not below its ramp length");

    a_jq_level: assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop |-> job_valid) and (jq_cnt_reg <= tswg_pkg::Q_FULL))
        else $error("job queue underflow or overflow");
`endif

endmodule

// ===== design/tswg_back.sv =====
// back end: multiplies span by the ramp offset, divides by the ramp length one
// quotient bit a cycle and queues the samples; depends on tswg_pkg
module tswg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tswg_pkg::job_t  job,
    input  logic            job_valid,
    output logic            job_pop,
    input  logic            pop,
    output logic            empty,
    output tswg_pkg::samp_t sample,
    output logic            period_end
);

    localparam int CNT_W = $clog2(tswg_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(tswg_pkg::DIV_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } bstate_t;

    bstate_t          state_reg;
    bstate_t          state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    tswg_pkg::job_t   job_reg;
    tswg_pkg::len_t   rem_reg;
    tswg_pkg::samp_t  quo_reg;

    tswg_pkg::prod_t  prod;
    tswg_pkg::pos_t   trial;
    tswg_pkg::pos_t   den_x;
    logic             ge;
    tswg_pkg::len_t   rem_step;
    tswg_pkg::samp_t  quo_step;
    tswg_pkg::samp_t  res;

    tswg_pkg::samp_t  rq_samp_reg [2];
    logic             rq_pend_reg [2];
    tswg_pkg::qptr_t  rq_wr_ptr_reg;
    tswg_pkg::qptr_t  rq_rd_ptr_reg;
    tswg_pkg::qcnt_t  rq_cnt_reg;
    tswg_pkg::qcnt_t  rq_cnt_next;
    logic             rq_push;
    logic             rq_pop;

    always_comb
    begin
        prod     = tswg_pkg::prod_t'(job_reg.span) * tswg_pkg::prod_t'(job_reg.num);
        // restoring step: shift in the next dividend bit, subtract when it fits
        trial    = {rem_reg, quo_reg[tswg_pkg::SAMP_W-1]};
        den_x    = tswg_pkg::pos_t'(job_reg.den);
        ge       = (trial >= den_x);
        rem_step = ge ? tswg_pkg::len_t'(trial - den_x) : trial[tswg_pkg::LEN_W-1:0];
        quo_step = {quo_reg[tswg_pkg::SAMP_W-2:0], ge};
        res      = job_reg.sub ? (job_reg.base - quo_reg) : (job_reg.base + quo_reg);
    end

    assign rq_push = (state_reg == ST_DONE) && (rq_cnt_reg != tswg_pkg::Q_FULL);
    assign rq_pop  = pop && !empty;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        job_pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cnt_next   = CNT_LOAD;
                state_next = (job_reg.den == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rq_push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        unique case ({rq_push, rq_pop})
            2'b10:   rq_cnt_next = rq_cnt_reg + tswg_pkg::qcnt_t'(1);
            2'b01:   rq_cnt_next = rq_cnt_reg - tswg_pkg::qcnt_t'(1);
            default: rq_cnt_next = rq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rq_cnt_reg <= rq_cnt_next;
            if (rq_push)
            begin
                rq_wr_ptr_reg <= rq_wr_ptr_reg + tswg_pkg::qptr_t'(1);
            end
            if (rq_pop)
            begin
                rq_rd_ptr_reg <= rq_rd_ptr_reg + tswg_pkg::qptr_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_MUL)
        begin
            // quotient fits in a sample, so the top bits start below the divisor
            rem_reg <= prod[tswg_pkg::PROD_W-1:tswg_pkg::SAMP_W];
            quo_reg <= (job_reg.den == '0) ? '0 : prod[tswg_pkg::SAMP_W-1:0];
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
        if (rq_push)
        begin
            rq_samp_reg[rq_wr_ptr_reg] <= res;
            rq_pend_reg[rq_wr_ptr_reg] <= job_reg.pend;
        end
    end

    assign empty      = (rq_cnt_reg == '0);
    assign sample     = rq_samp_reg[rq_rd_ptr_reg];
    assign period_end = rq_pend_reg[rq_rd_ptr_reg];

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < job_reg.den))
        else $error("divider remainder not below divisor");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> (res <= tswg_pkg::FULL_SCALE))
        else $error("sample beyond full scale");

    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg == ST_MUL))
        else $error("job taken without starting the multiply");
`endif

endmodule
